// ===== rtl/mshb_pkg.sv =====
// ----------------------------------------------------------------------------
// mshb_pkg
// Shared types and constants of the multichannel soft PWM / H-bridge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mshb_pkg;

    localparam int CHANNELS_DEF = 16;

    localparam int PIN_W   = 8;
    localparam int DUTY_W  = 8;
    localparam int SPEED_W = 16;

    // Motor speed is clamped to this magnitude.
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd255;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sd255;
    localparam logic [DUTY_W-1:0]         DUTY_MAX  = 8'd255;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_MOTOR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_TICK
    } state_t;

    // One channel table entry as held in memory.
    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic [DUTY_W-1:0] duty;
    } chan_t;

endpackage

`default_nettype wire

// ===== rtl/mshb_chan_ram.sv =====
// ----------------------------------------------------------------------------
// mshb_chan_ram
// Channel table memory: one write port, one registered read port, with the
// write data forwarded when both ports address the same entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mshb_chan_ram #(
    parameter int CHANNELS = mshb_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire                 aclk,
    input  wire                 wr_en,
    input  wire [IDX_W-1:0]     wr_addr,
    input  mshb_pkg::chan_t     wr_data,
    input  wire [IDX_W-1:0]     rd_addr,
    output mshb_pkg::chan_t     rd_data
);

    mshb_pkg::chan_t mem [0:CHANNELS-1];
    mshb_pkg::chan_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/multichannel_soft_pwm_hbridge.sv =====
// ----------------------------------------------------------------------------
// multichannel_soft_pwm_hbridge
// Table of PWM channels bound to pins, with duty writes, H-bridge motor
// commands and a phase tick that reports the level of every active channel.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_func s_pin s_pin_b s_duty   | in
//          | s_speed                                      |
//  result  | m_valid m_ready m_from_tick m_out_pin m_level | out
//          | m_status m_last                              |
//
//  A tick walks the active channels, one per cycle while the result is free.
//  A duty write scans from entry 0 to the pin's entry, or to the fill count
//  for a new pin or a full table; a motor command is two writes.
//  Active channels always form a prefix of the table, so a fill count stands
//  in for per-entry valid bits and reset needs no clearing pass.
//  A stalled result word holds the walk in place until it is taken.
//
`timescale 1ns / 1ps
`default_nettype none

module multichannel_soft_pwm_hbridge #(
    parameter int CHANNELS = mshb_pkg::CHANNELS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [1:0]                    s_func,
    input  wire [mshb_pkg::PIN_W-1:0]    s_pin,
    input  wire [mshb_pkg::PIN_W-1:0]    s_pin_b,
    input  wire [mshb_pkg::DUTY_W-1:0]   s_duty,
    input  wire signed [mshb_pkg::SPEED_W-1:0] s_speed,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_from_tick,
    output logic [mshb_pkg::PIN_W-1:0]   m_out_pin,
    output logic                         m_level,
    output logic                         m_status,
    output logic                         m_last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(CHANNELS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    mshb_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [mshb_pkg::DUTY_W-1:0] phase_reg, phase_next;
    logic [mshb_pkg::PIN_W-1:0]  pin_reg, pin_next;
    logic [mshb_pkg::PIN_W-1:0]  pin_b_reg, pin_b_next;
    logic [mshb_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic [mshb_pkg::DUTY_W-1:0] rev_reg, rev_next;
    logic more_reg, more_next;

    logic m_valid_reg;
    logic m_from_tick_reg, m_level_reg, m_status_reg, m_last_reg;
    logic [mshb_pkg::PIN_W-1:0] m_out_pin_reg;

    mshb_pkg::chan_t rd_data;
    mshb_pkg::chan_t wr_data;
    logic            wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic out_free;
    logic hit, miss, full, tick_last;
    logic emit_status, emit_tick;
    logic [mshb_pkg::DUTY_W-1:0] fwd_duty, rev_duty;
    logic signed [mshb_pkg::SPEED_W-1:0] speed_neg;

    mshb_chan_ram #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Clamp the motor speed and split it into forward and reverse duty.
    always_comb begin
        speed_neg = -s_speed;
        if (s_speed > mshb_pkg::SPEED_MAX) begin
            fwd_duty = mshb_pkg::DUTY_MAX;
        end else if (s_speed > 0) begin
            fwd_duty = s_speed[mshb_pkg::DUTY_W-1:0];
        end else begin
            fwd_duty = '0;
        end
        if (s_speed < mshb_pkg::SPEED_MIN) begin
            rev_duty = mshb_pkg::DUTY_MAX;
        end else if (s_speed < 0) begin
            rev_duty = speed_neg[mshb_pkg::DUTY_W-1:0];
        end else begin
            rev_duty = '0;
        end
    end

    // Output and datapath control.
    always_comb begin
        s_ready     = (state_reg == mshb_pkg::ST_IDLE);
        out_free    = !m_valid_reg || m_ready;
        miss        = (idx_reg == fill_reg);
        hit         = !miss && (rd_data.pin == pin_reg);
        full        = (fill_reg == FILL_MAX);
        tick_last   = (idx_reg == (fill_reg - CNT_ONE));
        emit_status = (state_reg == mshb_pkg::ST_FIND) && (hit || miss) && out_free;
        emit_tick   = (state_reg == mshb_pkg::ST_TICK) && out_free;
        wr_en       = emit_status && (hit || !full);
        wr_addr     = hit ? idx_reg[IDX_W-1:0] : fill_reg[IDX_W-1:0];
        wr_data.pin  = pin_reg;
        wr_data.duty = duty_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        pin_next   = pin_reg;
        pin_b_next = pin_b_reg;
        duty_next  = duty_reg;
        rev_next   = rev_reg;
        more_next  = more_reg;
        unique case (state_reg)
            mshb_pkg::ST_IDLE: begin
                idx_next = '0;
                if (s_valid) begin
                    unique case (s_func)
                        mshb_pkg::FUNC_TICK: begin
                            phase_next = phase_reg + 1'b1;
                            if (fill_reg != '0) begin
                                state_next = mshb_pkg::ST_TICK;
                            end
                        end
                        mshb_pkg::FUNC_WRITE: begin
                            pin_next   = s_pin;
                            duty_next  = s_duty;
                            more_next  = 1'b0;
                            state_next = mshb_pkg::ST_FIND;
                        end
                        mshb_pkg::FUNC_MOTOR: begin
                            pin_next   = s_pin;
                            duty_next  = fwd_duty;
                            pin_b_next = s_pin_b;
                            rev_next   = rev_duty;
                            more_next  = 1'b1;
                            state_next = mshb_pkg::ST_FIND;
                        end
                        default: begin
                            state_next = mshb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mshb_pkg::ST_FIND: begin
                if (emit_status) begin
                    if (!hit && !full) begin
                        fill_next = fill_reg + CNT_ONE;
                    end
                    idx_next = '0;
                    if (more_reg) begin
                        // Second half of a motor command: the reverse pin.
                        pin_next  = pin_b_reg;
                        duty_next = rev_reg;
                        more_next = 1'b0;
                    end else begin
                        state_next = mshb_pkg::ST_IDLE;
                    end
                end else if (!hit && !miss) begin
                    idx_next = idx_reg + CNT_ONE;
                end
            end
            mshb_pkg::ST_TICK: begin
                if (emit_tick) begin
                    idx_next = idx_reg + CNT_ONE;
                    if (tick_last) begin
                        state_next = mshb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = mshb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mshb_pkg::ST_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            phase_reg <= '0;
            more_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge aclk) begin
        pin_reg   <= pin_next;
        pin_b_reg <= pin_b_next;
        duty_reg  <= duty_next;
        rev_reg   <= rev_next;
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_status || emit_tick) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_status) begin
            m_from_tick_reg <= 1'b0;
            m_out_pin_reg   <= '0;
            m_level_reg     <= 1'b0;
            m_status_reg    <= (!hit && full) ? mshb_pkg::STATUS_FULL : mshb_pkg::STATUS_OK;
            m_last_reg      <= !more_reg;
        end else if (emit_tick) begin
            m_from_tick_reg <= 1'b1;
            m_out_pin_reg   <= rd_data.pin;
            m_level_reg     <= (phase_reg < rd_data.duty);
            m_status_reg    <= mshb_pkg::STATUS_OK;
            m_last_reg      <= tick_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_from_tick = m_from_tick_reg;
    assign m_out_pin   = m_out_pin_reg;
    assign m_level     = m_level_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// ===== sim/tb_multichannel_soft_pwm_hbridge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_soft_pwm_hbridge
// Self-checking bench for the soft PWM channel table. A directed opening walks
// through an empty-table tick, the unused selector, allocation, duty updates,
// motor speed clamping, a pair that names one pin twice and a full table. A
// long random run follows. Every accepted word is scored against a local
// model of the channel table and the phase counter. Both handshakes idle at
// random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------

module tb_multichannel_soft_pwm_hbridge;

    localparam int CHANNELS    = mshb_pkg::CHANNELS_DEF;
    localparam int PIN_W       = mshb_pkg::PIN_W;
    localparam int DUTY_W      = mshb_pkg::DUTY_W;
    localparam int SPEED_W     = mshb_pkg::SPEED_W;
    localparam int RANDOM_CMDS = 394;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        mshb_pkg::func_t           func;
        logic [PIN_W-1:0]          pin;
        logic [PIN_W-1:0]          pin_b;
        logic [DUTY_W-1:0]         duty;
        logic signed [SPEED_W-1:0] speed;
    } pwm_cmd_t;

    typedef struct packed {
        logic             from_tick;
        logic [PIN_W-1:0] out_pin;
        logic             level;
        logic             status;
        logic             last;
    } pwm_word_t;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_EVERY3,
        RX_RARE
    } rx_mode_t;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_func      = 2'd0;
    logic [PIN_W-1:0]          s_pin       = '0;
    logic [PIN_W-1:0]          s_pin_b     = '0;
    logic [DUTY_W-1:0]         s_duty      = '0;
    logic signed [SPEED_W-1:0] s_speed     = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic                      m_from_tick;
    logic [PIN_W-1:0]          m_out_pin;
    logic                      m_level;
    logic                      m_status;
    logic                      m_last;

    multichannel_soft_pwm_hbridge #(
        .CHANNELS (CHANNELS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_pin       (s_pin),
        .s_pin_b     (s_pin_b),
        .s_duty      (s_duty),
        .s_speed     (s_speed),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_from_tick (m_from_tick),
        .m_out_pin   (m_out_pin),
        .m_level     (m_level),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Local copy of the channel table and the phase counter.
    logic [PIN_W-1:0]  chan_pin  [CHANNELS];
    logic [DUTY_W-1:0] chan_duty [CHANNELS];
    bit                chan_used [CHANNELS];
    logic [7:0]        pwm_phase;

    pwm_cmd_t  pending_cmds[$];
    pwm_word_t expected_words[$];

    int total_cmds    = 0;
    int accepted_cmds = 0;
    int mismatches    = 0;
    int words_checked = 0;
    int n_ticks       = 0;
    int n_writes      = 0;
    int n_motors      = 0;
    int n_ignored     = 0;
    int n_full        = 0;
    int n_high        = 0;
    int cycle_count   = 0;
    bit in_taken      = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                      words_checked, name, got, want));
        end
    endtask

    // Updates the entry bound to the pin, or claims the lowest free entry.
    function automatic bit table_write(input logic [PIN_W-1:0] pin,
                                       input logic [DUTY_W-1:0] duty);
        for (int i = 0; i < CHANNELS; i++) begin
            if (chan_used[i] && chan_pin[i] == pin) begin
                chan_duty[i] = duty;
                return 1'b1;
            end
        end
        for (int i = 0; i < CHANNELS; i++) begin
            if (!chan_used[i]) begin
                chan_used[i] = 1'b1;
                chan_pin[i]  = pin;
                chan_duty[i] = duty;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic push_status(input bit ok, input bit last);
        pwm_word_t w;
        w.from_tick = 1'b0;
        w.out_pin   = '0;
        w.level     = 1'b0;
        w.status    = ok ? mshb_pkg::STATUS_OK : mshb_pkg::STATUS_FULL;
        w.last      = last;
        if (!ok) begin
            n_full++;
        end
        expected_words.push_back(w);
    endtask

    task automatic predict_words(input pwm_cmd_t c);
        pwm_word_t         w;
        int                n_active;
        int                k;
        int                spd;
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
        bit                ok;
        case (c.func)
            mshb_pkg::FUNC_TICK: begin
                n_ticks++;
                pwm_phase = pwm_phase + 8'd1;
                n_active  = 0;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (chan_used[i]) begin
                        n_active++;
                    end
                end
                k = 0;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (chan_used[i]) begin
                        w.from_tick = 1'b1;
                        w.out_pin   = chan_pin[i];
                        w.level     = pwm_phase < chan_duty[i];
                        w.status    = mshb_pkg::STATUS_OK;
                        w.last      = (k == n_active - 1);
                        if (w.level) begin
                            n_high++;
                        end
                        expected_words.push_back(w);
                        k++;
                    end
                end
            end
            mshb_pkg::FUNC_WRITE: begin
                n_writes++;
                ok = table_write(c.pin, c.duty);
                push_status(ok, 1'b1);
            end
            mshb_pkg::FUNC_MOTOR: begin
                n_motors++;
                spd = c.speed;
                if (spd > int'(mshb_pkg::SPEED_MAX)) begin
                    spd = int'(mshb_pkg::SPEED_MAX);
                end
                if (spd < int'(mshb_pkg::SPEED_MIN)) begin
                    spd = int'(mshb_pkg::SPEED_MIN);
                end
                fwd = (spd > 0) ? 8'(spd) : 8'd0;
                rev = (spd < 0) ? 8'(-spd) : 8'd0;
                // Both halves allocate on their own; the second write wins
                // when the pair names one pin twice.
                ok = table_write(c.pin, fwd);
                push_status(ok, 1'b0);
                ok = table_write(c.pin_b, rev);
                push_status(ok, 1'b1);
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    function automatic pwm_cmd_t mk_cmd(input mshb_pkg::func_t f, input int pin,
                                        input int pin_b, input int duty,
                                        input int speed);
        pwm_cmd_t c;
        c.func  = f;
        c.pin   = pin[PIN_W-1:0];
        c.pin_b = pin_b[PIN_W-1:0];
        c.duty  = duty[DUTY_W-1:0];
        c.speed = speed[SPEED_W-1:0];
        return c;
    endfunction

    // Pins bound by the directed part; random traffic mostly reuses them.
    const int known_pins[CHANNELS] = '{0, 255, 10, 11, 12, 13, 20, 21, 170, 85,
                                       30, 31, 32, 33, 34, 35};

    function automatic int pick_pin();
        if ($urandom_range(0, 3) != 0) begin
            return known_pins[$urandom_range(0, CHANNELS - 1)];
        end
        return $urandom_range(0, 255);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard and model update, both on the rising edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pwm_word_t want;
        pwm_cmd_t  c;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected, pin %0h",
                                              m_out_pin));
                end else begin
                    want = expected_words.pop_front();
                    cmp_field("from_tick", m_from_tick, want.from_tick);
                    cmp_field("out_pin", m_out_pin, want.out_pin);
                    cmp_field("level", m_level, want.level);
                    cmp_field("status", m_status, want.status);
                    cmp_field("last", m_last, want.last);
                end
                words_checked++;
            end
            if (s_valid && s_ready) begin
                c.func  = mshb_pkg::func_t'(s_func);
                c.pin   = s_pin;
                c.pin_b = s_pin_b;
                c.duty  = s_duty;
                c.speed = s_speed;
                predict_words(c);
                accepted_cmds++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver: bursts of back-to-back words with random gaps.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        pwm_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // Word still waiting for acceptance; hold everything.
        end else if (burst_left > 0 && pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            s_valid    <= 1'b1;
            s_func     <= c.func;
            s_pin      <= c.pin;
            s_pin_b    <= c.pin_b;
            s_duty     <= c.duty;
            s_speed    <= c.speed;
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: a changing stall pattern plus one long hold-off.
    // ------------------------------------------------------------------
    rx_mode_t rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       rx_count  = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && accepted_cmds >= HOLD_AFTER) begin
            // The sender keeps offering words, so the block has to back up.
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            rx_count++;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= $urandom_range(0, 1);
                RX_EVERY3: m_ready <= (rx_count % 3) != 0;
                default:   m_ready <= $urandom_range(0, 7) != 0;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d commands taken, %0d words due",
                     cycle_count, accepted_cmds, total_cmds, expected_words.size());
            $display("** multichannel_soft_pwm_hbridge: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        pwm_cmd_t c;
        int       counted;
        int       pick;

        pwm_phase = 8'd0;
        for (int i = 0; i < CHANNELS; i++) begin
            chan_pin[i]  = 8'd255;
            chan_duty[i] = 8'd0;
            chan_used[i] = 1'b0;
        end

        // Empty table: the tick only moves the phase, the unused selector
        // does nothing at all.
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_NONE, 255, 255, 255, -1));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_WRITE, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_WRITE, 255, 0, 255, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_WRITE, 0, 0, 200, 0));
        // Speed clamping from both extremes, zero, the upper limit and just past the lower one.
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 10, 11, 0, 32767));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 10, 11, 0, -32768));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 10, 11, 0, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 12, 13, 0, 255));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 12, 13, 0, -256));
        // One pin used for both halves of a pair.
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 20, 20, 0, 100));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 21, 21, 0, -100));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_WRITE, 170, 0, 85, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_WRITE, 85, 0, 170, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_TICK, 0, 0, 0, 0));
        for (int i = 0; i < 6; i++) begin
            pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_WRITE, 30 + i, 0, i * 50, 0));
        end
        // The table is now full: a new pin is dropped, and a pair can
        // succeed on one half and fail on the other.
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_WRITE, 99, 0, 7, 0));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_MOTOR, 0, 100, 0, 50));
        pending_cmds.push_back(mk_cmd(mshb_pkg::FUNC_TICK, 0, 0, 0, 0));

        counted = 0;
        while (counted < RANDOM_CMDS) begin
            pick    = $urandom_range(0, 99);
            c.func  = (pick < 42) ? mshb_pkg::FUNC_TICK :
                      (pick < 67) ? mshb_pkg::FUNC_WRITE :
                      (pick < 93) ? mshb_pkg::FUNC_MOTOR : mshb_pkg::FUNC_NONE;
            c.pin   = 8'(pick_pin());
            c.pin_b = 8'(pick_pin());
            c.duty  = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                  : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0:       c.speed = 16'($urandom_range(0, 600) - 300);
                1:       c.speed = 16'($urandom_range(0, 65535));
                2:       c.speed = 16'($urandom_range(0, 510) - 255);
                default: begin
                    case ($urandom_range(0, 5))
                        0:       c.speed = 16'sd255;
                        1:       c.speed = -16'sd255;
                        2:       c.speed = 16'sd256;
                        3:       c.speed = -16'sd256;
                        4:       c.speed = 16'sd0;
                        default: c.speed = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    endcase
                end
            endcase
            pending_cmds.push_back(c);
            counted++;
        end
        total_cmds = pending_cmds.size();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_cmds < total_cmds || expected_words.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (expected_words.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_words.size()));
        end
        $display("Ran %0d commands: %0d ticks, %0d duty writes, %0d motor pairs, %0d ignored.",
                 accepted_cmds, n_ticks, n_writes, n_motors, n_ignored);
        $display("Scored %0d result words: %0d high levels, %0d dropped writes, %0d mismatches.",
                 words_checked, n_high, n_full, mismatches);
        if (mismatches == 0) begin
            $display("** multichannel_soft_pwm_hbridge: PASSED **");
        end else begin
            $display("** multichannel_soft_pwm_hbridge: FAILED **");
        end
        $finish;
    end

endmodule
